>>> hdl/vpt_pkg.sv
`timescale 1ns / 1ps

package vpt_pkg;

	localparam int CHAR_W   = 21;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 16;

	localparam int          MAX_NEST_DEF   = 255;
	localparam longint      MAX_LENGTH_DEF = 65535;

	// Output queue: deep enough to take two results while two more still wait.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_OPEN   = CHAR_W'(8'h5B);
	localparam logic [CHAR_W-1:0] CH_CLOSE  = CHAR_W'(8'h5D);
	localparam logic [CHAR_W-1:0] CH_DOT    = CHAR_W'(8'h2E);
	localparam logic [CHAR_W-1:0] CH_QUOTE  = CHAR_W'(8'h22);
	localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(8'h5C);

	typedef enum logic [KIND_W-1:0] {
		KIND_ROOT_CHAR  = 3'd0,
		KIND_CHILD_CHAR = 3'd1,
		KIND_SUB_CHAR   = 3'd2,
		KIND_ROOT_END   = 3'd3,
		KIND_CHILD_END  = 3'd4,
		KIND_SUB_END    = 3'd5,
		KIND_STATUS     = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NAME    = 2'd1,
		ST_BRACKET = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		M_EXPECT    = 6'b000001,
		M_NAME      = 6'b000010,
		M_SUB       = 6'b000100,
		M_AFTER_SUB = 6'b001000,
		M_DONE      = 6'b010000,
		M_FAILED    = 6'b100000
	} mode_t;

	typedef struct packed {
		kind_t                kind;
		logic [CHAR_W-1:0]    chr;
		status_t              status;
		logic [POS_W-1:0]     pos;
		logic                 last;
	} result_t;

endpackage

>>> hdl/vpt_parser.sv
`timescale 1ns / 1ps

module vpt_parser import vpt_pkg::*; #(
	parameter int     MAX_NEST   = MAX_NEST_DEF,
	parameter longint MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              end_mark,
	output result_t           res0,
	output result_t           res1,
	output logic [1:0]        res_cnt
);

	localparam int NW = $clog2(MAX_NEST + 1);
	localparam int PW = $clog2(MAX_LENGTH + 1);

	mode_t            mode_q, mode_d;
	logic             root_q, root_d;
	logic             lit_q, lit_d;
	logic             bs_q, bs_d;
	logic [NW-1:0]    nest_q, nest_d;
	logic [PW-1:0]    pos_q, pos_d;
	status_t          outcome_q, outcome_d;
	logic [PW-1:0]    err_q, err_d;

	logic [PW-1:0]    pos_inc;
	logic [PW-1:0]    fin_pos_sel;
	logic [POS_W-1:0] fin_pos;
	status_t          fin_status;
	logic             is_delim;
	kind_t            name_char_kind;
	kind_t            name_end_kind;
	result_t          fin_res;

	assign pos_inc  = (pos_q < PW'(MAX_LENGTH)) ? pos_q + PW'(1) : pos_q;
	assign is_delim = (char_code == CH_OPEN) || (char_code == CH_CLOSE) ||
		(char_code == CH_DOT);
	assign name_char_kind = root_q ? KIND_CHILD_CHAR : KIND_ROOT_CHAR;
	assign name_end_kind  = root_q ? KIND_CHILD_END : KIND_ROOT_END;

	// Status and position reported by an end marker, picked from the current mode.
	always_comb begin
		fin_status  = ST_OK;
		fin_pos_sel = '0;
		unique case (mode_q)
			M_EXPECT: begin
				fin_status  = ST_NAME;
				fin_pos_sel = pos_q;
			end
			M_SUB: begin
				fin_status  = ST_BRACKET;
				fin_pos_sel = pos_q;
			end
			M_FAILED: begin
				fin_status  = outcome_q;
				fin_pos_sel = err_q;
			end
			default: ;
		endcase
	end

	// The reported position is clamped to the output field.
	generate
		if (PW > POS_W) begin : g_clamp
			assign fin_pos = (|fin_pos_sel[PW-1:POS_W]) ? '1 : fin_pos_sel[POS_W-1:0];
		end else begin : g_extend
			assign fin_pos = POS_W'(fin_pos_sel);
		end
	endgenerate

	assign fin_res = '{kind: KIND_STATUS, chr: '0, status: fin_status, pos: fin_pos,
		last: 1'b1};

	always_comb begin
		mode_d    = mode_q;
		root_d    = root_q;
		lit_d     = lit_q;
		bs_d      = bs_q;
		nest_d    = nest_q;
		pos_d     = pos_q;
		outcome_d = outcome_q;
		err_d     = err_q;
		res0      = '0;
		res1      = '0;
		res_cnt   = 2'd0;
		if (end_mark) begin
			if (mode_q == M_NAME) begin
				res0    = '{kind: name_end_kind, chr: '0, status: ST_OK, pos: '0, last: 1'b0};
				res1    = fin_res;
				res_cnt = 2'd2;
			end else begin
				res0    = fin_res;
				res_cnt = 2'd1;
			end
			// Back to the reset state for the next expression.
			mode_d    = M_EXPECT;
			root_d    = 1'b0;
			lit_d     = 1'b0;
			bs_d      = 1'b0;
			nest_d    = '0;
			pos_d     = '0;
			outcome_d = ST_OK;
			err_d     = '0;
		end else begin
			pos_d = pos_inc;
			unique case (mode_q)
				M_EXPECT: begin
					if (is_delim) begin
						outcome_d = ST_NAME;
						err_d     = pos_inc;
						mode_d    = M_FAILED;
					end else begin
						mode_d  = M_NAME;
						res0    = '{kind: name_char_kind, chr: char_code, status: ST_OK,
							pos: '0, last: 1'b0};
						res_cnt = 2'd1;
					end
				end
				M_NAME: begin
					if (is_delim) begin
						res0    = '{kind: name_end_kind, chr: '0, status: ST_OK, pos: '0,
							last: 1'b0};
						res_cnt = 2'd1;
						root_d  = 1'b1;
						if (char_code == CH_DOT) begin
							mode_d = M_EXPECT;
						end else if (char_code == CH_OPEN) begin
							mode_d = M_SUB;
							lit_d  = 1'b0;
							bs_d   = 1'b0;
							nest_d = '0;
						end else begin
							mode_d = M_DONE;
						end
					end else begin
						res0    = '{kind: name_char_kind, chr: char_code, status: ST_OK,
							pos: '0, last: 1'b0};
						res_cnt = 2'd1;
					end
				end
				M_SUB: begin
					if (!lit_q && char_code == CH_CLOSE && nest_q == '0) begin
						// Unmatched close bracket ends the subscript.
						mode_d  = M_AFTER_SUB;
						res0    = '{kind: KIND_SUB_END, chr: '0, status: ST_OK, pos: '0,
							last: 1'b0};
						res_cnt = 2'd1;
					end else begin
						if (char_code == CH_QUOTE) begin
							if (!lit_q) begin
								lit_d = 1'b1;
							end else if (!bs_q) begin
								lit_d = 1'b0;
							end
						end else if (char_code == CH_OPEN && !lit_q) begin
							if (nest_q < NW'(MAX_NEST)) begin
								nest_d = nest_q + NW'(1);
							end
						end else if (char_code == CH_CLOSE && !lit_q) begin
							nest_d = nest_q - NW'(1);
						end
						bs_d    = (char_code == CH_BSLASH);
						res0    = '{kind: KIND_SUB_CHAR, chr: char_code, status: ST_OK,
							pos: '0, last: 1'b0};
						res_cnt = 2'd1;
					end
				end
				M_AFTER_SUB: begin
					if (char_code == CH_DOT) begin
						mode_d = M_EXPECT;
					end else if (char_code == CH_OPEN) begin
						mode_d = M_SUB;
						lit_d  = 1'b0;
						bs_d   = 1'b0;
						nest_d = '0;
					end else begin
						mode_d = M_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_EXPECT;
			root_q    <= 1'b0;
			lit_q     <= 1'b0;
			bs_q      <= 1'b0;
			nest_q    <= '0;
			pos_q     <= '0;
			outcome_q <= ST_OK;
			err_q     <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			root_q    <= root_d;
			lit_q     <= lit_d;
			bs_q      <= bs_d;
			nest_q    <= nest_d;
			pos_q     <= pos_d;
			outcome_q <= outcome_d;
			err_q     <= err_d;
		end
	end

endmodule

>>> hdl/vpt_out_queue.sv
`timescale 1ns / 1ps

module vpt_out_queue import vpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] push_cnt,
	input  result_t    push0,
	input  result_t    push1,
	output logic       room,
	output logic       valid,
	input  logic       pop,
	output result_t    head
);

	result_t            mem [QDEPTH];
	logic [QPTR_W-1:0]  wp_q;
	logic [QPTR_W-1:0]  rp_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic [QCNT_W-1:0]  add;
	logic               take;

	// Room for the largest burst one item can cause.
	assign room  = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign valid = (cnt_q != '0);
	assign take  = pop && valid;
	assign add   = push ? QCNT_W'(push_cnt) : '0;
	assign head  = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push && push_cnt != 2'd0) begin
			mem[wp_q] <= push0;
		end
		if (push && push_cnt == 2'd2) begin
			mem[wp_q + QPTR_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(add);
			rp_q  <= rp_q + QPTR_W'(take);
			cnt_q <= cnt_q + add - QCNT_W'(take);
		end
	end

endmodule

>>> hdl/variable_path_tokenizer_core.sv
`timescale 1ns / 1ps

// Variable path tokenizer. One character of a path such as name.child[expr].x
// enters per word on the slave stream, and tlast on a word marks the end of the
// expression (its data is then ignored). Every word is handled in the cycle it
// is accepted: the parser state is a handful of flags and counters updated by a
// single layer of logic, and the events it produces are written straight into a
// four-entry output queue. A character word causes at most one event; an end
// word causes the final status event, preceded by a name-end event when the
// expression ended inside a name. s_tready drops only while the queue holds
// more than two events. With the master side always ready the block takes one
// word per cycle as long as events do not outnumber words; each end word that
// closes a name adds an extra event, and once such extra events have filled the
// queue past two, s_tready drops for a cycle while the master side catches up.
// Accepted words' events are registered into the queue, behind any still waiting.
// After an end word the parser is back in its reset state, ready for the next
// path. The master tlast is set on the final status event only; the nesting
// depth saturates at MAX_NEST and the character count at MAX_LENGTH.
module variable_path_tokenizer_core import vpt_pkg::*; #(
	parameter int     MAX_NEST   = MAX_NEST_DEF,
	parameter longint MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [20:0] char_code, [23:21] zero
	input  logic        s_tlast,    // end_mark
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // [20:0] event_char, [22:21] parse_status,
	                                // [38:23] error_position, [39] zero
	output logic [2:0]  m_tuser,    // [2:0] event_kind
	output logic        m_tlast     // is_last
);

	logic       accept;
	result_t    res0;
	result_t    res1;
	logic [1:0] res_cnt;
	logic       q_room;
	result_t    head;

	assign s_tready = q_room;
	assign accept   = s_tvalid && s_tready;

	vpt_parser #(
		.MAX_NEST   (MAX_NEST),
		.MAX_LENGTH (MAX_LENGTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (s_tdata[CHAR_W-1:0]),
		.end_mark  (s_tlast),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt)
	);

	vpt_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cnt (res_cnt),
		.push0    (res0),
		.push1    (res1),
		.room     (q_room),
		.valid    (m_tvalid),
		.pop      (m_tready),
		.head     (head)
	);

	// Event words are packed from the low end: character, status, position.
	assign m_tdata = {1'b0, head.pos, head.status, head.chr};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

>>> hdl/vpt_checker.sv
`timescale 1ns / 1ps

module vpt_checker import vpt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// The final status event, and only it, closes an expression.
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
		else $error("tlast does not match the final status kind");

	// Events other than the final status carry no status and no position.
	a_no_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_STATUS) |-> (m_tdata[38:21] == '0))
		else $error("status or position set on a character event");

	// An accepted end word leaves at least its status event waiting.
	a_end_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("no event after an end word");

	// A stalled event word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast)))
		else $error("event word changed while stalled");

endmodule

bind variable_path_tokenizer_core vpt_checker u_vpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
